FILE: rtl/core/vtm_pkg.sv
package vtm_pkg;

  localparam int unsigned LANES  = 4;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_XFORM = 1'b1;

  typedef logic signed [ELEM_W-1:0] vtm_elem_t;
  typedef logic signed [PROD_W-1:0] vtm_prod_t;
  typedef logic signed [PAIR_W-1:0] vtm_pair_t;
  typedef logic signed [SUM_W-1:0]  vtm_sum_t;

  typedef vtm_elem_t [LANES-1:0] vtm_vec_t;

  // Load enables for the three lane pipeline stages.
  typedef struct packed {
    logic mul_en;
    logic pair_en;
    logic sum_en;
  } vtm_adv_t;

endpackage

FILE: rtl/core/vtm_lane.sv
module vtm_lane (
  input  logic               clk,
  input  vtm_pkg::vtm_adv_t  adv,
  input  vtm_pkg::vtm_vec_t  row,
  input  vtm_pkg::vtm_vec_t  vec,
  output vtm_pkg::vtm_sum_t  sum
);

  vtm_pkg::vtm_prod_t prod [vtm_pkg::LANES];
  vtm_pkg::vtm_pair_t pair_a;
  vtm_pkg::vtm_pair_t pair_b;

  // Four products of one matrix row with the incoming vector.
  always_ff @(posedge clk) begin
    if (adv.mul_en) begin
      for (int j = 0; j < vtm_pkg::LANES; j++) begin
        prod[j] <= vtm_pkg::vtm_prod_t'($signed(row[j]) * $signed(vec[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.pair_en) begin
      pair_a <= vtm_pkg::vtm_pair_t'(prod[0]) + vtm_pkg::vtm_pair_t'(prod[1]);
      pair_b <= vtm_pkg::vtm_pair_t'(prod[2]) + vtm_pkg::vtm_pair_t'(prod[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.sum_en) begin
      sum <= vtm_pkg::vtm_sum_t'(pair_a) + vtm_pkg::vtm_sum_t'(pair_b);
    end
  end

endmodule

FILE: rtl/core/vtm_merge.sv
module vtm_merge #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  vtm_pkg::vtm_sum_t  sums [vtm_pkg::LANES],
  output vtm_pkg::vtm_vec_t  res
);

  vtm_pkg::vtm_sum_t  shifted [vtm_pkg::LANES];
  vtm_pkg::vtm_vec_t  sat;

  // Arithmetic shift floors toward minus infinity; then clamp to 32 bits.
  always_comb begin
    for (int i = 0; i < vtm_pkg::LANES; i++) begin
      shifted[i] = sums[i] >>> FRAC_BITS;
      if ((&shifted[i][vtm_pkg::SUM_W-1:vtm_pkg::ELEM_W-1]) ||
          !(|shifted[i][vtm_pkg::SUM_W-1:vtm_pkg::ELEM_W-1])) begin
        sat[i] = shifted[i][vtm_pkg::ELEM_W-1:0];
      end else if (shifted[i][vtm_pkg::SUM_W-1]) begin
        sat[i] = {1'b1, {(vtm_pkg::ELEM_W-1){1'b0}}};
      end else begin
        sat[i] = {1'b0, {(vtm_pkg::ELEM_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= sat;
    end
  end

endmodule

FILE: rtl/core/vertex_transform_mat4_vec4.sv
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+-------------------------------------
// input    | in_valid / in_stall (to src)  | func, row_index, in_x/y/z/w
// output   | out_valid / out_stall (to us) | out_x, out_y, out_z, out_w
//
// A transform request passes four registered stages on its way to out_valid:
// the sixteen 32x32 multipliers, the pair-sum and row-sum adders in each row
// lane, and the shift and saturation in the merge stage. One request per cycle
// is sustained while out_stall stays low. A load request updates the matrix
// at the edge where it is accepted and produces no result. Reset clears the
// matrix and all valid flags. Each stage holds while the stage after it is
// full and stalled, so in_stall rises only when all four stages are occupied.
module vertex_transform_mat4_vec4 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     func,
  input  logic [1:0]               row_index,
  input  logic signed [31:0]       in_x,
  input  logic signed [31:0]       in_y,
  input  logic signed [31:0]       in_z,
  input  logic signed [31:0]       in_w,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic signed [31:0]       out_w
);

  // The matrix, one register row per lane, cleared by reset.
  vtm_pkg::vtm_vec_t  mat [vtm_pkg::LANES];
  vtm_pkg::vtm_vec_t  vec;
  vtm_pkg::vtm_sum_t  sums [vtm_pkg::LANES];
  vtm_pkg::vtm_vec_t  res;
  vtm_pkg::vtm_adv_t  adv;

  // Valid flags of the product, pair-sum and row-sum stages.
  logic mul_valid;
  logic pair_valid;
  logic sum_valid;

  logic out_ready;
  logic sum_ready;
  logic pair_ready;
  logic mul_ready;
  logic accept;
  logic xform;

  assign vec = {in_w, in_z, in_y, in_x};

  // A stage may load when it is empty or when its content moves on.
  assign out_ready  = !out_valid || !out_stall;
  assign sum_ready  = !sum_valid || out_ready;
  assign pair_ready = !pair_valid || sum_ready;
  assign mul_ready  = !mul_valid || pair_ready;

  assign in_stall = !mul_ready;
  assign accept   = in_valid && mul_ready;
  assign xform    = accept && (func == vtm_pkg::FUNC_XFORM);

  assign adv.mul_en  = xform;
  assign adv.pair_en = pair_ready && mul_valid;
  assign adv.sum_en  = sum_ready && pair_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < vtm_pkg::LANES; r++) begin
        mat[r] <= '0;
      end
    end else if (accept && (func == vtm_pkg::FUNC_LOAD)) begin
      mat[row_index] <= vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid  <= 1'b0;
      pair_valid <= 1'b0;
      sum_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid <= xform;
      end
      if (pair_ready) begin
        pair_valid <= mul_valid;
      end
      if (sum_ready) begin
        sum_valid <= pair_valid;
      end
      if (out_ready) begin
        out_valid <= sum_valid;
      end
    end
  end

  // One lane per matrix row; each sees the same vector.
  for (genvar g = 0; g < vtm_pkg::LANES; g++) begin : g_lane
    vtm_lane u_lane (
      .clk (clk),
      .adv (adv),
      .row (mat[g]),
      .vec (vec),
      .sum (sums[g])
    );
  end

  vtm_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk  (clk),
    .en   (out_ready && sum_valid),
    .sums (sums),
    .res  (res)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

`ifndef SYNTHESIS
  // A result can only appear after the row-sum stage held one.
  a_out_from_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(sum_valid))
    else $error("result appeared without a finished row sum");

  // The source is held off only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (mul_valid && pair_valid && sum_valid && out_valid))
    else $error("input stalled with a free pipeline stage");

  // An accepted load writes the addressed matrix row.
  a_load_row: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == vtm_pkg::FUNC_LOAD)) |=>
      (mat[$past(row_index)] == $past(vec)))
    else $error("matrix row not updated by load");

  // A stalled result keeps its valid flag.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
`endif

endmodule

FILE: bench/tb.sv
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = 16;

  // Handy Q16.16 values for the directed table.
  localparam vtm_pkg::vtm_elem_t Q_ONE = 32'sh0001_0000;
  localparam vtm_pkg::vtm_elem_t Q_MAX = 32'sh7FFF_FFFF;
  localparam vtm_pkg::vtm_elem_t Q_MIN = 32'sh8000_0000;

  // Saturation bounds of a dot product after the fraction bits are shifted out.
  localparam logic signed [67:0] DOT_MAX = 68'sd2147483647;
  localparam logic signed [67:0] DOT_MIN = -68'sd2147483648;

  localparam int N_RANDOM       = 1627;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;

  // One request as the sender offers it. Lane 0 of data is x, lane 3 is w.
  typedef struct packed {
    logic      func;
    logic [1:0] row;
    vtm_pkg::vtm_vec_t data;
  } vertex_req_t;

  // A row of the directed table. When typed is set, want holds the result
  // worked out by hand; otherwise the result comes from the predictor.
  typedef struct packed {
    vertex_req_t req;
    logic        typed;
    vtm_pkg::vtm_vec_t want;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              func;
  logic [1:0]        row_index;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [31:0] in_w;
  logic              out_valid;
  logic              out_stall;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;

  // Our own copy of the matrix, updated at the edge a load request is taken.
  vtm_pkg::vtm_elem_t model_matrix [4][4];

  // Results owed by the block, oldest first.
  vtm_pkg::vtm_vec_t pending_vertices [$];

  int    mismatches   = 0;
  int    results_seen = 0;
  int    burst_left   = 0;
  string lane_name [4] = '{"out_x", "out_y", "out_z", "out_w"};

  vertex_transform_mat4_vec4 #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .row_index(row_index),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .in_w     (in_w),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .out_w    (out_w)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic vtm_pkg::vtm_vec_t vec4(vtm_pkg::vtm_elem_t x, vtm_pkg::vtm_elem_t y,
                                             vtm_pkg::vtm_elem_t z, vtm_pkg::vtm_elem_t w);
    vtm_pkg::vtm_vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    return v;
  endfunction

  // Each lane is the exact dot product of one matrix row with the vector.
  // Four 64-bit products fit easily in 68 bits, so the sum never wraps. The
  // arithmetic shift floors negative sums, then the value is clamped.
  function automatic vtm_pkg::vtm_vec_t transform_vertex(vtm_pkg::vtm_vec_t v);
    logic signed [67:0] acc;
    logic signed [67:0] a;
    logic signed [67:0] b;
    vtm_pkg::vtm_vec_t res;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        a = 68'(model_matrix[r][c]);
        b = 68'(v[c]);
        acc += a * b;
      end
      acc = acc >>> FRAC;
      if (acc > DOT_MAX) begin
        res[r] = Q_MAX;
      end else if (acc < DOT_MIN) begin
        res[r] = Q_MIN;
      end else begin
        res[r] = acc[31:0];
      end
    end
    return res;
  endfunction

  // Mostly small fixed-point numbers and full random words, with a steady
  // share of the corner values that stress saturation and flooring.
  function automatic vtm_pkg::vtm_elem_t pick_elem();
    vtm_pkg::vtm_elem_t e;
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) begin
      case ($urandom_range(0, 6))
        0: e = Q_MAX;
        1: e = Q_MIN;
        2: e = Q_ONE;
        3: e = -Q_ONE;
        4: e = 32'sd1;
        5: e = 32'sd0;
        default: e = -32'sd1;
      endcase
    end else if (k < 6) begin
      e = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    end else begin
      e = $urandom;
    end
    return e;
  endfunction

  // Puts a request on the input port and holds it until it is taken. At the
  // accepting edge the model either stores the row or books the result the
  // block now owes us.
  task automatic offer_request(input vertex_req_t r, input logic typed,
                               input vtm_pkg::vtm_vec_t want);
    in_valid  <= 1'b1;
    func      <= r.func;
    row_index <= r.row;
    in_x      <= r.data[0];
    in_y      <= r.data[1];
    in_z      <= r.data[2];
    in_w      <= r.data[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.func == vtm_pkg::FUNC_LOAD) begin
      for (int c = 0; c < 4; c++) model_matrix[r.row][c] = r.data[c];
    end else begin
      pending_vertices.push_back(typed ? want : transform_vertex(r.data));
    end
  endtask

  // The sender runs in bursts. Most are short, some are long enough to keep
  // the pipeline streaming at full rate; each burst ends in a short gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                              : $urandom_range(0, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Main sequence: reset, the directed table, the random stream, then drain.
  initial begin : stimulus
    plan_row_t   plan [$];
    vertex_req_t r;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    func      <= vtm_pkg::FUNC_LOAD;
    row_index <= 2'd0;
    in_x      <= '0;
    in_y      <= '0;
    in_z      <= '0;
    in_w      <= '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) model_matrix[i][j] = '0;
    end

    // Right after reset the matrix is zero, so transforms give zero whatever
    // the vector holds, and the row index of a transform is ignored.
    plan.push_back('{'{vtm_pkg::FUNC_XFORM, 2'd0, vec4(Q_ONE, Q_ONE, Q_ONE, Q_ONE)},
                     1'b1, vec4(0, 0, 0, 0)});
    plan.push_back('{'{vtm_pkg::FUNC_XFORM, 2'd3, vec4(Q_MAX, Q_MIN, Q_MAX, Q_MIN)},
                     1'b1, vec4(0, 0, 0, 0)});

    // With the identity matrix the vector comes back unchanged, even at the
    // ends of the range.
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd0, vec4(Q_ONE, 0, 0, 0)}, 1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd1, vec4(0, Q_ONE, 0, 0)}, 1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd2, vec4(0, 0, Q_ONE, 0)}, 1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd3, vec4(0, 0, 0, Q_ONE)}, 1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_XFORM, 2'd1, vec4(Q_ONE, 32'shFFFE_0000, Q_MAX, Q_MIN)},
                     1'b1, vec4(Q_ONE, 32'shFFFE_0000, Q_MAX, Q_MIN)});

    // Extreme rows: all max, all min, the smallest step, and a lone min.
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd0, vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX)},
                     1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd1, vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN)},
                     1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd2, vec4(32'sd1, 0, 0, 0)}, 1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd3, vec4(Q_MIN, 0, 0, 0)}, 1'b0, '0});

    // Overflow both ways next to an in-range lane.
    plan.push_back('{'{vtm_pkg::FUNC_XFORM, 2'd2, vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX)},
                     1'b1, vec4(Q_MAX, Q_MIN, 32'sh0000_7FFF, Q_MIN)});
    // Small negative sums floor toward minus infinity: -1 >>> 16 is -1.
    plan.push_back('{'{vtm_pkg::FUNC_XFORM, 2'd0, vec4(-32'sd1, 0, 0, 0)},
                     1'b1, vec4(32'shFFFF_8000, 32'sh0000_8000, -32'sd1, 32'sh0000_8000)});
    // Min times min is positive and must clamp high.
    plan.push_back('{'{vtm_pkg::FUNC_XFORM, 2'd1, vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN)},
                     1'b1, vec4(Q_MIN, Q_MAX, 32'shFFFF_8000, Q_MAX)});

    // Lane x lands one step above the largest value and clamps; the next
    // transform hits the smallest value exactly without clamping.
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd0, vec4(Q_ONE, 32'sd1, 0, 0)}, 1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_XFORM, 2'd3, vec4(Q_MAX, Q_ONE, 0, 0)},
                     1'b1, vec4(Q_MAX, Q_MIN, 32'sh0000_7FFF, Q_MIN)});
    plan.push_back('{'{vtm_pkg::FUNC_XFORM, 2'd2, vec4(Q_ONE, 0, 0, 0)},
                     1'b1, vec4(Q_ONE, Q_MIN, 32'sd1, Q_MIN)});

    // Mixed values, checked against the predictor.
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd2,
                     vec4(32'sh0001_8000, 32'shFFFF_4000, 32'sh1234_5678, 32'sh8000_0001)},
                     1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_XFORM, 2'd0,
                     vec4(32'sh0002_0000, 32'shFFFF_0000, 32'sh0000_0003, 32'sh0000_8000)},
                     1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_LOAD, 2'd1,
                     vec4(-32'sd1, 32'sh0003_0000, 32'shFFFF_8000, 32'sh7FFF_0000)},
                     1'b0, '0});
    plan.push_back('{'{vtm_pkg::FUNC_XFORM, 2'd1,
                     vec4(32'shFFFD_4000, Q_ONE, 32'sh0000_C000, 32'shFFFF_FFFE)},
                     1'b0, '0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      offer_request(plan[i].req, plan[i].typed, plan[i].want);
      pace_sender();
    end

    // Random stream: about one request in four reloads a row, the rest
    // transform vectors through whatever matrix has been built up.
    for (int n = 0; n < N_RANDOM; n++) begin
      r.func = ($urandom_range(0, 3) == 0) ? vtm_pkg::FUNC_LOAD : vtm_pkg::FUNC_XFORM;
      r.row  = 2'($urandom_range(0, 3));
      for (int c = 0; c < 4; c++) r.data[c] = pick_elem();
      offer_request(r, 1'b0, '0);
      pace_sender();
    end
    in_valid <= 1'b0;

    // Let every owed result come out, then watch a little longer for extras.
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // The receiver stalls in stretches of its own: free running, light random
  // stalls, heavy random stalls, and a fixed one-in-three pattern. Twice in
  // the run it holds off for a long stretch so the pipeline fills and the
  // block has to stall its input while the sender keeps offering.
  initial begin : receiver
    int mode;
    int span;
    int tick;
    int hold_offs;
    out_stall <= 1'b0;
    tick = 0;
    hold_offs = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (tick % 3 == 0);
        endcase
      end
      if (hold_offs < 2 && results_seen > 300 * (hold_offs + 1)) begin
        hold_offs++;
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Every result taken is compared lane by lane with the oldest owed result.
  always @(posedge clk) begin : check_results
    vtm_pkg::vtm_vec_t want;
    vtm_pkg::vtm_vec_t got;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      got = vec4(out_x, out_y, out_z, out_w);
      if (pending_vertices.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got %08h %08h %08h %08h",
                 $time, got[0], got[1], got[2], got[3]);
      end else begin
        want = pending_vertices.pop_front();
        for (int c = 0; c < 4; c++) begin
          if (got[c] !== want[c]) begin
            mismatches++;
            $display("%0t: %s expected %08h, got %08h",
                     $time, lane_name[c], want[c], got[c]);
          end
        end
      end
    end
  end

  // Ends the run if neither channel moves a request for too long. The long
  // receiver hold-off is well inside the limit.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/vtm_pkg.sv
rtl/core/vtm_lane.sv
rtl/core/vtm_merge.sv
rtl/core/vertex_transform_mat4_vec4.sv
bench/tb.sv
